[design/utf8d_pkg.sv]
// ----------------------------------------------------------------------------
// utf8d_pkg
// shared types and constants for the utf-8 decoder
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

    localparam int CP_W        = 21;
    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_CP         = 21'h10FFFF;
    localparam logic [CP_W-1:0] LIMIT_3BYTE    = 21'h00FFFF;
    localparam logic [CP_W-1:0] LIMIT_2BYTE    = 21'h0007FF;
    localparam logic [CP_W-1:0] LIMIT_1BYTE    = 21'h00007F;
    localparam logic [CP_W-1:0] END_MARKER_CP  = 21'h000000;

    // one result of the decoder
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            eot;
    } result_t;

    // all results caused by one input item
    typedef struct packed {
        logic [1:0]                   count;
        result_t [MAX_RESULTS-1:0]    slot;
    } job_t;

endpackage

`default_nettype wire

[design/utf8d_front.sv]
// ----------------------------------------------------------------------------
// utf8d_front
// sequence tracking and classification of each byte into a result job
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic [7:0]           text_byte,
    input  wire logic                 last_byte,
    output utf8d_pkg::job_t           job,
    output logic                      job_valid
);

    logic [1:0]                 seq_len_reg, seq_len_next;
    logic [1:0]                 left_reg, left_next;
    logic [utf8d_pkg::CP_W-1:0] acc_reg, acc_next;
    logic                       ended_reg, ended_next;

    always_comb
    begin
        utf8d_pkg::result_t [3:0]   cand;
        logic [1:0]                 cnt;
        logic                       pending;
        logic                       is_cont;
        logic                       fresh;
        logic                       nul_here;
        logic [utf8d_pkg::CP_W-1:0] acc_new;
        logic                       bad;

        cand         = '0;
        cnt          = 2'd0;
        seq_len_next = seq_len_reg;
        left_next    = left_reg;
        acc_next     = acc_reg;
        ended_next   = ended_reg;
        pending      = (left_reg != 2'd0);
        is_cont      = (text_byte[7:6] == 2'b10);
        fresh        = !pending || !is_cont;
        nul_here     = fresh && (text_byte == 8'h00);
        acc_new      = {acc_reg[utf8d_pkg::CP_W-7:0], text_byte[5:0]};

        unique case (seq_len_reg)
            2'd1:    bad = (acc_new <= utf8d_pkg::LIMIT_1BYTE);
            2'd2:    bad = (acc_new <= utf8d_pkg::LIMIT_2BYTE);
            default: bad = (acc_new <= utf8d_pkg::LIMIT_3BYTE) || (acc_new > utf8d_pkg::MAX_CP);
        endcase

        if (ended_reg)
        begin
            if (last_byte)
            begin
                seq_len_next = 2'd0;
                left_next    = 2'd0;
                acc_next     = '0;
                ended_next   = 1'b0;
            end
        end
        else
        begin
            if (pending && is_cont)
            begin
                acc_next  = acc_new;
                left_next = left_reg - 2'd1;
                if (left_reg == 2'd1)
                begin
                    cand[cnt].cp  = bad ? utf8d_pkg::REPLACEMENT_CP : acc_new;
                    cand[cnt].eot = 1'b0;
                    cnt           = cnt + 2'd1;
                    seq_len_next  = 2'd0;
                    acc_next      = '0;
                end
            end
            else
            begin
                // bad follower: report the dropped sequence first
                if (pending)
                begin
                    cand[cnt].cp  = utf8d_pkg::REPLACEMENT_CP;
                    cand[cnt].eot = 1'b0;
                    cnt           = cnt + 2'd1;
                end
                seq_len_next = 2'd0;
                left_next    = 2'd0;
                acc_next     = '0;
                if (text_byte == 8'h00)
                begin
                    cand[cnt].cp  = utf8d_pkg::END_MARKER_CP;
                    cand[cnt].eot = 1'b1;
                    cnt           = cnt + 2'd1;
                    ended_next    = 1'b1;
                end
                else if (text_byte[7] == 1'b0)
                begin
                    cand[cnt].cp  = {13'd0, text_byte};
                    cand[cnt].eot = 1'b0;
                    cnt           = cnt + 2'd1;
                end
                else if (text_byte[7:5] == 3'b110)
                begin
                    seq_len_next = 2'd1;
                    left_next    = 2'd1;
                    acc_next     = {16'd0, text_byte[4:0]};
                end
                else if (text_byte[7:4] == 4'b1110)
                begin
                    seq_len_next = 2'd2;
                    left_next    = 2'd2;
                    acc_next     = {17'd0, text_byte[3:0]};
                end
                else if (text_byte[7:3] == 5'b11110)
                begin
                    seq_len_next = 2'd3;
                    left_next    = 2'd3;
                    acc_next     = {18'd0, text_byte[2:0]};
                end
                else if (!is_cont)
                begin
                    // bad lead byte
                    cand[cnt].cp  = utf8d_pkg::REPLACEMENT_CP;
                    cand[cnt].eot = 1'b0;
                    cnt           = cnt + 2'd1;
                end
            end

            if (last_byte)
            begin
                if (!nul_here)
                begin
                    if (left_next != 2'd0)
                    begin
                        cand[cnt].cp  = utf8d_pkg::REPLACEMENT_CP;
                        cand[cnt].eot = 1'b0;
                        cnt           = cnt + 2'd1;
                    end
                    cand[cnt].cp  = utf8d_pkg::END_MARKER_CP;
                    cand[cnt].eot = 1'b1;
                    cnt           = cnt + 2'd1;
                end
                seq_len_next = 2'd0;
                left_next    = 2'd0;
                acc_next     = '0;
                ended_next   = 1'b0;
            end
        end

        job.count = cnt;
        job.slot  = cand[2:0];
        job_valid = accept && (cnt != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= 2'd0;
            left_reg    <= 2'd0;
            acc_reg     <= '0;
            ended_reg   <= 1'b0;
        end
        else if (accept)
        begin
            seq_len_reg <= seq_len_next;
            left_reg    <= left_next;
            acc_reg     <= acc_next;
            ended_reg   <= ended_next;
        end
    end

endmodule

`default_nettype wire

[design/utf8d_queue.sv]
// ----------------------------------------------------------------------------
// utf8d_queue
// short job queue between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire utf8d_pkg::job_t push_job,
    input  wire logic            pop,
    output utf8d_pkg::job_t      head,
    output logic                 head_valid,
    output logic                 full
);

    utf8d_pkg::job_t [utf8d_pkg::QUEUE_DEPTH-1:0] entry_reg;
    logic [utf8d_pkg::QPTR_W-1:0]                 wr_ptr_reg, rd_ptr_reg;
    logic [utf8d_pkg::QCNT_W-1:0]                 count_reg, count_next;

    localparam logic [utf8d_pkg::QPTR_W-1:0] LAST_PTR =
        utf8d_pkg::QPTR_W'(utf8d_pkg::QUEUE_DEPTH - 1);
    localparam logic [utf8d_pkg::QPTR_W-1:0] ONE_PTR =
        utf8d_pkg::QPTR_W'(1);
    localparam logic [utf8d_pkg::QCNT_W-1:0] DEPTH_CNT =
        utf8d_pkg::QCNT_W'(utf8d_pkg::QUEUE_DEPTH);
    localparam logic [utf8d_pkg::QCNT_W-1:0] ONE_CNT =
        utf8d_pkg::QCNT_W'(1);

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == DEPTH_CNT);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + ONE_CNT;
        else if (pop && !push)
            count_next = count_reg - ONE_CNT;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + ONE_PTR;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + ONE_PTR;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[design/utf8d_back.sv]
// ----------------------------------------------------------------------------
// utf8d_back
// walks the results of each job into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire utf8d_pkg::job_t             head,
    input  wire logic                        head_valid,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [utf8d_pkg::CP_W-1:0]       code_point,
    output logic                             end_of_text,
    output logic                             run_last
);

    logic [1:0]                 idx_reg;
    logic                       valid_reg;
    logic [utf8d_pkg::CP_W-1:0] cp_reg;
    logic                       eot_reg;
    logic                       last_reg;
    logic                       load;
    logic                       final_slot;
    utf8d_pkg::result_t         cur;

    assign load       = head_valid && (!valid_reg || !out_stall);
    assign final_slot = (idx_reg == head.count - 2'd1);
    assign pop        = load && final_slot;

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur = head.slot[0];
            2'd1:    cur = head.slot[1];
            default: cur = head.slot[2];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= final_slot ? 2'd0 : idx_reg + 2'd1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg   <= cur.cp;
            eot_reg  <= cur.eot;
            last_reg <= final_slot;
        end
    end

    assign out_valid   = valid_reg;
    assign code_point  = cp_reg;
    assign end_of_text = eot_reg;
    assign run_last    = last_reg;

endmodule

`default_nettype wire

[design/utf8_to_code_point_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder
// utf-8 byte stream in, unicode code points and end markers out
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid, in_stall  | text_byte[7:0], last_byte
//  out     | output    | out_valid, out_stall| code_point[20:0], end_of_text, run_last
//
//  one item is taken per cycle while the job queue has room
//  each item makes zero to three results, sent one per cycle from the output register while out_stall is low
//  the first result passes through the job queue and then the output register when nothing waits ahead
//  in_stall rises only when the two-entry job queue is full
//  rst_n clears the sequence state, the queue and the output valid
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_code_point_decoder (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             text_byte,
    input  wire logic                   last_byte,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [utf8d_pkg::CP_W-1:0]  code_point,
    output logic                        end_of_text,
    output logic                        run_last
);

    utf8d_pkg::job_t job;
    utf8d_pkg::job_t head;
    logic            job_valid;
    logic            head_valid;
    logic            pop;
    logic            full;
    logic            accept;

    // stall follows only the registered queue fill
    assign in_stall = full;
    assign accept   = in_valid && !full;

    // front: tracks the pending sequence and builds the result job
    utf8d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (text_byte),
        .last_byte (last_byte),
        .job       (job),
        .job_valid (job_valid)
    );

    // items with no result never enter the queue
    utf8d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_valid),
        .push_job   (job),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    // back: emits the job's results in order, flagging the final one
    utf8d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_point  (code_point),
        .end_of_text (end_of_text),
        .run_last    (run_last)
    );

endmodule

`default_nettype wire

[bench/utf8_to_code_point_decoder_tb.sv]
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder_tb
// byte-stream test of the utf-8 decoder. a short table of hand-picked bytes
// (extremes, overlong and out-of-range forms, bad leads and followers, nul
// and last-byte handling) is followed by random text that is mostly
// well-formed sequences with malformed ones and noise mixed in. every
// accepted byte runs through a behavioral decoder in the bench, and each
// result leaving the block is checked field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module utf8_to_code_point_decoder_tb;

    localparam int CP_W = utf8d_pkg::CP_W;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = utf8d_pkg::REPLACEMENT_CP;
    localparam logic [CP_W-1:0] MAX_CP         = utf8d_pkg::MAX_CP;
    localparam logic [CP_W-1:0] LIMIT_3BYTE    = utf8d_pkg::LIMIT_3BYTE;
    localparam logic [CP_W-1:0] LIMIT_2BYTE    = utf8d_pkg::LIMIT_2BYTE;
    localparam logic [CP_W-1:0] LIMIT_1BYTE    = utf8d_pkg::LIMIT_1BYTE;
    localparam logic [CP_W-1:0] END_MARKER_CP  = utf8d_pkg::END_MARKER_CP;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_ITEMS  = 70;
    localparam int DRAIN_AT      = 60;
    localparam int QUIET_LIMIT   = 200;
    localparam int SETTLE_CYCLES = 10;
    localparam int NUM_ROWS      = 30;

    // byte classes of utf-8
    localparam logic [7:0] NUL_BYTE  = 8'h00;
    localparam logic [7:0] HIGH_BIT  = 8'h80;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;
    localparam logic [7:0] MASK_2    = 8'hE0;
    localparam logic [7:0] LEAD_2    = 8'hC0;
    localparam logic [7:0] MASK_3    = 8'hF0;
    localparam logic [7:0] LEAD_3    = 8'hE0;
    localparam logic [7:0] MASK_4    = 8'hF8;
    localparam logic [7:0] LEAD_4    = 8'hF0;
    localparam logic [7:0] BAD_LEAD  = 8'hF8;

    localparam logic [CP_W-1:0] NO_CP = '0;

    // smallest (nul aside) and largest code point of each encoded length
    localparam logic [CP_W-1:0] CP_LO [4] = '{21'h000001, 21'h000080, 21'h000800, 21'h010000};
    localparam logic [CP_W-1:0] CP_HI [4] = '{LIMIT_1BYTE, LIMIT_2BYTE, LIMIT_3BYTE, MAX_CP};

    // one expected result of the decoder
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            eot;
        logic            fin;
    } cp_item_t;

    // one input byte; typed rows carry their own results (at most two)
    typedef struct packed {
        logic [7:0]      tb;
        logic            lb;
        logic            typed;
        logic [1:0]      n;
        logic [CP_W-1:0] cp_a;
        logic            eot_a;
        logic [CP_W-1:0] cp_b;
        logic            eot_b;
    } stim_row_t;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_stall;
    logic [7:0]      text_byte = '0;
    logic            last_byte = 1'b0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    logic [CP_W-1:0] code_point;
    logic            end_of_text;
    logic            run_last;

    // bench copy of the decoder state
    logic [1:0]      pend_len  = '0;
    logic [1:0]      pend_left = '0;
    logic [CP_W-1:0] pend_bits = '0;
    logic            text_done = 1'b0;

    cp_item_t step_cps[$];      // results of the byte just taken
    cp_item_t expected_cps[$];  // results still to come out, oldest first
    logic [7:0] chunk[$];       // bytes of the random sequence being built

    int  n_errors     = 0;
    int  live_items   = 0;
    int  rx_wait      = 0;
    int  quiet_cycles = 0;
    bit  tx_idle      = 1'b1;
    bit  rx_idle      = 1'b1;
    bit  hold_for_drain = 1'b0;

    // directed bytes, in order; the random part follows
    stim_row_t stim_table [NUM_ROWS] = '{
        // ascii extremes right after reset
        '{8'h41, 1'b0, 1'b1, 2'd1, 21'h000041,     1'b0, NO_CP,         1'b0},
        '{8'h7F, 1'b0, 1'b1, 2'd1, 21'h00007F,     1'b0, NO_CP,         1'b0},
        // overlong two-byte form of nul
        '{8'hC0, 1'b0, 1'b0, 2'd0, NO_CP,          1'b0, NO_CP,         1'b0},
        '{8'h80, 1'b0, 1'b1, 2'd1, REPLACEMENT_CP, 1'b0, NO_CP,         1'b0},
        // largest two-byte value
        '{8'hDF, 1'b0, 1'b0, 2'd0, NO_CP,          1'b0, NO_CP,         1'b0},
        '{8'hBF, 1'b0, 1'b0, 2'd0, NO_CP,          1'b0, NO_CP,         1'b0},
        // overlong three-byte form
        '{8'hE0, 1'b0, 1'b0, 2'd0, NO_CP,          1'b0, NO_CP,         1'b0},
        '{8'h9F, 1'b0, 1'b0, 2'd0, NO_CP,          1'b0, NO_CP,         1'b0},
        '{8'hBF, 1'b0, 1'b1, 2'd1, REPLACEMENT_CP, 1'b0, NO_CP,         1'b0},
        // surrogate passes through
        '{8'hED, 1'b0, 1'b0, 2'd0, NO_CP,          1'b0, NO_CP,         1'b0},
        '{8'hA0, 1'b0, 1'b0, 2'd0, NO_CP,          1'b0, NO_CP,         1'b0},
        '{8'h80, 1'b0, 1'b0, 2'd0, NO_CP,          1'b0, NO_CP,         1'b0},
        // largest code point
        '{8'hF4, 1'b0, 1'b0, 2'd0, NO_CP,          1'b0, NO_CP,         1'b0},
        '{8'h8F, 1'b0, 1'b0, 2'd0, NO_CP,          1'b0, NO_CP,         1'b0},
        '{8'hBF, 1'b0, 1'b0, 2'd0, NO_CP,          1'b0, NO_CP,         1'b0},
        '{8'hBF, 1'b0, 1'b0, 2'd0, NO_CP,          1'b0, NO_CP,         1'b0},
        // one above the largest code point
        '{8'hF4, 1'b0, 1'b0, 2'd0, NO_CP,          1'b0, NO_CP,         1'b0},
        '{8'h90, 1'b0, 1'b0, 2'd0, NO_CP,          1'b0, NO_CP,         1'b0},
        '{8'h80, 1'b0, 1'b0, 2'd0, NO_CP,          1'b0, NO_CP,         1'b0},
        '{8'h80, 1'b0, 1'b1, 2'd1, REPLACEMENT_CP, 1'b0, NO_CP,         1'b0},
        // stray continuation is dropped silently
        '{8'h80, 1'b0, 1'b1, 2'd0, NO_CP,          1'b0, NO_CP,         1'b0},
        // bad lead byte
        '{8'hFF, 1'b0, 1'b1, 2'd1, REPLACEMENT_CP, 1'b0, NO_CP,         1'b0},
        // bad follower, then the byte decoded on its own
        '{8'hE2, 1'b0, 1'b0, 2'd0, NO_CP,          1'b0, NO_CP,         1'b0},
        '{8'h41, 1'b0, 1'b1, 2'd2, REPLACEMENT_CP, 1'b0, 21'h000041,    1'b0},
        // nul inside a sequence, then bytes ignored up to the last one
        '{8'hC3, 1'b0, 1'b0, 2'd0, NO_CP,          1'b0, NO_CP,         1'b0},
        '{8'h00, 1'b0, 1'b1, 2'd2, REPLACEMENT_CP, 1'b0, END_MARKER_CP, 1'b1},
        '{8'h55, 1'b0, 1'b1, 2'd0, NO_CP,          1'b0, NO_CP,         1'b0},
        '{8'h66, 1'b1, 1'b1, 2'd0, NO_CP,          1'b0, NO_CP,         1'b0},
        // last byte leaves a sequence open
        '{8'hF0, 1'b1, 1'b1, 2'd2, REPLACEMENT_CP, 1'b0, END_MARKER_CP, 1'b1},
        // nul as the last byte gives a single end marker
        '{8'h00, 1'b1, 1'b1, 2'd1, END_MARKER_CP,  1'b1, NO_CP,         1'b0}
    };

    utf8_to_code_point_decoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .text_byte   (text_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_point  (code_point),
        .end_of_text (end_of_text),
        .run_last    (run_last)
    );

    always
    begin
        #HALF_PERIOD clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // behavioral decoder
    // ------------------------------------------------------------------------

    function automatic logic [CP_W-1:0] checked_value(logic [CP_W-1:0] v, logic [1:0] len);
        logic bad;
        case (len)
            2'd1:    bad = (v <= LIMIT_1BYTE);
            2'd2:    bad = (v <= LIMIT_2BYTE);
            default: bad = (v <= LIMIT_3BYTE) || (v > MAX_CP);
        endcase
        return bad ? REPLACEMENT_CP : v;
    endfunction

    task automatic emit_cp(input logic [CP_W-1:0] cp, input logic eot);
        cp_item_t r;
        r.cp  = cp;
        r.eot = eot;
        r.fin = 1'b0;
        step_cps = {step_cps, r};
    endtask

    task automatic clear_decoder();
        pend_len  = '0;
        pend_left = '0;
        pend_bits = '0;
        text_done = 1'b0;
    endtask

    // byte seen with no sequence open
    task automatic start_sequence(input logic [7:0] b);
        if (b == NUL_BYTE)
        begin
            emit_cp(END_MARKER_CP, 1'b1);
            text_done = 1'b1;
        end
        else if ((b & HIGH_BIT) == 8'h00)
            emit_cp(CP_W'(b), 1'b0);
        else if ((b & MASK_2) == LEAD_2)
        begin
            pend_len  = 2'd1;
            pend_left = 2'd1;
            pend_bits = CP_W'(b[4:0]);
        end
        else if ((b & MASK_3) == LEAD_3)
        begin
            pend_len  = 2'd2;
            pend_left = 2'd2;
            pend_bits = CP_W'(b[3:0]);
        end
        else if ((b & MASK_4) == LEAD_4)
        begin
            pend_len  = 2'd3;
            pend_left = 2'd3;
            pend_bits = CP_W'(b[2:0]);
        end
        else if ((b & CONT_MASK) != CONT_TAG)
            emit_cp(REPLACEMENT_CP, 1'b0);
    endtask

    // all results of one accepted byte go to step_cps
    task automatic decode_utf8_byte(input logic [7:0] b, input logic is_last);
        logic nul_here;
        nul_here = 1'b0;
        step_cps.delete();
        if (text_done)
        begin
            if (is_last)
                clear_decoder();
        end
        else
        begin
            if (pend_left != 2'd0)
            begin
                if ((b & CONT_MASK) == CONT_TAG)
                begin
                    pend_bits = {pend_bits[CP_W-7:0], b[5:0]};
                    pend_left = pend_left - 2'd1;
                    if (pend_left == 2'd0)
                    begin
                        emit_cp(checked_value(pend_bits, pend_len), 1'b0);
                        pend_len  = '0;
                        pend_bits = '0;
                    end
                end
                else
                begin
                    // broken sequence: report it, then take the byte on its own
                    emit_cp(REPLACEMENT_CP, 1'b0);
                    pend_len  = '0;
                    pend_left = '0;
                    pend_bits = '0;
                    nul_here  = (b == NUL_BYTE);
                    start_sequence(b);
                end
            end
            else
            begin
                nul_here = (b == NUL_BYTE);
                start_sequence(b);
            end
            if (is_last)
            begin
                if (!nul_here)
                begin
                    if (pend_left != 2'd0)
                        emit_cp(REPLACEMENT_CP, 1'b0);
                    emit_cp(END_MARKER_CP, 1'b1);
                end
                clear_decoder();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // hand one byte to the block and record what it should produce
    task automatic send_byte(input stim_row_t row);
        int gap;
        bit was_ended;
        gap = tx_idle ? int'($urandom_range(0, 9)) : 0;
        if (hold_for_drain)
        begin
            // let the block run dry before the next byte
            in_valid <= 1'b0;
            do @(posedge clk); while (expected_cps.size() != 0);
            hold_for_drain = 1'b0;
        end
        else if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= row.tb;
        last_byte <= row.lb;
        do @(posedge clk); while (in_stall);

        was_ended = text_done;
        decode_utf8_byte(row.tb, row.lb);
        if (row.typed)
        begin
            step_cps.delete();
            if (row.n >= 2'd1)
                emit_cp(row.cp_a, row.eot_a);
            if (row.n == 2'd2)
                emit_cp(row.cp_b, row.eot_b);
        end
        if (step_cps.size() > 0)
            step_cps[step_cps.size()-1].fin = 1'b1;
        expected_cps = {expected_cps, step_cps};
        if (!was_ended)
            live_items++;
    endtask

    // add one byte to the sequence being built
    task automatic append_byte(input logic [7:0] b);
        chunk = {chunk, b};
    endtask

    // append the bytes of cp in a len-byte form, overlong or not
    task automatic encode_seq(input logic [CP_W-1:0] cp, input int len);
        case (len)
            1:
                append_byte(8'(cp[6:0]));
            2:
            begin
                append_byte(LEAD_2 | 8'(cp[10:6]));
                append_byte(CONT_TAG | 8'(cp[5:0]));
            end
            3:
            begin
                append_byte(LEAD_3 | 8'(cp[15:12]));
                append_byte(CONT_TAG | 8'(cp[11:6]));
                append_byte(CONT_TAG | 8'(cp[5:0]));
            end
            default:
            begin
                append_byte(LEAD_4 | 8'(cp[20:18]));
                append_byte(CONT_TAG | 8'(cp[17:12]));
                append_byte(CONT_TAG | 8'(cp[11:6]));
                append_byte(CONT_TAG | 8'(cp[5:0]));
            end
        endcase
    endtask

    initial
    begin
        int        kind;
        int        len;
        bit        drained;
        bit        closes;
        stim_row_t row;

        drained = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed bytes with both sides idling at random
        for (int i = 0; i < NUM_ROWS; i++)
            send_byte(stim_table[i]);

        // random text: mostly well-formed sequences, some broken ones and noise
        live_items = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            // four phases of idling: none, sender only, receiver only, both
            tx_idle = ((live_items / 18) % 2) == 1;
            rx_idle = ((live_items / 36) % 2) == 1;
            if (!drained && live_items >= DRAIN_AT)
            begin
                hold_for_drain = 1'b1;
                drained        = 1'b1;
            end

            chunk.delete();
            closes = 1'b0;
            kind   = $urandom_range(0, 19);
            if (kind <= 11)
            begin
                // well-formed code point of any length
                len = $urandom_range(1, 4);
                encode_seq(CP_W'($urandom_range(CP_LO[len-1], CP_HI[len-1])), len);
            end
            else if (kind <= 13)
            begin
                // value that fits a shorter form
                len = $urandom_range(2, 4);
                encode_seq(CP_W'($urandom_range(0, CP_HI[len-2])), len);
            end
            else if (kind == 14)
                // four-byte value beyond the unicode range
                encode_seq(CP_W'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
            else if (kind == 15)
            begin
                // sequence cut short; the next byte breaks it
                len = $urandom_range(2, 4);
                encode_seq(CP_W'($urandom_range(CP_LO[len-1], CP_HI[len-1])), len);
                repeat ($urandom_range(1, len - 1)) void'(chunk.pop_back());
            end
            else if (kind == 16)
                append_byte(CONT_TAG | 8'($urandom_range(0, 63)));
            else if (kind == 17)
                append_byte(8'($urandom_range(BAD_LEAD, 8'hFF)));
            else if (kind == 18)
                append_byte(8'($urandom_range(0, 255)));
            else
            begin
                // nul ends the text, junk follows until the buffer closes
                append_byte(NUL_BYTE);
                repeat ($urandom_range(0, 3)) append_byte(8'($urandom_range(0, 255)));
                closes = 1'b1;
            end

            foreach (chunk[k])
            begin
                row    = '0;
                row.tb = chunk[k];
                row.lb = (closes && k == chunk.size() - 1) || ($urandom_range(0, 19) == 0);
                send_byte(row);
            end
        end

        in_valid <= 1'b0;
        while (expected_cps.size() != 0)
            @(posedge clk);
        // catch any result the block makes beyond the expected ones
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("utf8_to_code_point_decoder_tb: clean");
        else
            $display("utf8_to_code_point_decoder_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // output side: check each result, then draw the next stall
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        cp_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_cps.size() == 0)
            begin
                $error("result with nothing expected: code_point %h end_of_text %b",
                       code_point, end_of_text);
                n_errors++;
            end
            else
            begin
                want = expected_cps.pop_front();
                if (code_point !== want.cp)
                begin
                    $error("code_point: expected %h, got %h", want.cp, code_point);
                    n_errors++;
                end
                if (end_of_text !== want.eot)
                begin
                    $error("end_of_text: expected %b, got %b", want.eot, end_of_text);
                    n_errors++;
                end
                if (run_last !== want.fin)
                begin
                    $error("run_last: expected %b, got %b", want.fin, run_last);
                    n_errors++;
                end
            end
            rx_wait = rx_idle ? int'($urandom_range(0, 9)) : 0;
        end
        else if (rx_wait > 0)
            rx_wait--;
        out_stall <= rst_n && (rx_wait > 0);
    end

    // watchdog: too long without any item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("utf8_to_code_point_decoder_tb: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

[filelist.f]
design/utf8d_pkg.sv
design/utf8d_front.sv
design/utf8d_queue.sv
design/utf8d_back.sv
design/utf8_to_code_point_decoder.sv
bench/utf8_to_code_point_decoder_tb.sv
